/* hdl/vdr_pkg.sv */
// Shared types and constants of the VAT reordering block.
// No dependencies; imported by vat_dissimilarity_reordering and the testbench.
`timescale 1ns / 1ps

package vdr_pkg;

    // Defaults of the top-level parameters
    localparam int MAX_OBJECTS_DEF = 64;
    localparam int VALUE_BITS_DEF  = 16;

    // Field widths of the stream words
    localparam int IDX_W    = 6;
    localparam int DIS_W    = 16;
    localparam int COUNT_W  = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    // Input word layout, lowest bit first: row, col, dissimilarity, start
    localparam int ROW_LSB   = 0;
    localparam int COL_LSB   = ROW_LSB + IDX_W;
    localparam int DIS_LSB   = COL_LSB + IDX_W;
    localparam int START_LSB = DIS_LSB + DIS_W;

    // Configuration
    localparam int               APB_ADDR_W       = 3;
    localparam logic [2:0]       REG_OBJECT_COUNT = 3'd0;
    localparam logic [COUNT_W-1:0] OBJ_COUNT_RESET = 7'd64;

    // Command kinds on tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GET_A,
        ST_SCAN,
        ST_COMMIT
    } t_state;

endpackage

/* hdl/vat_dissimilarity_reordering.sv */
// VAT reordering top level: matrix store, order list and the scan sequencer.
// Depends on vdr_pkg and vdr_ram.
`timescale 1ns / 1ps

// Load words (tuser = 0) each write one dissimilarity and are taken one per
// cycle while idle; symmetry comes from storing only the (larger, smaller) half
// and ordering the indices the same way on reads. A start word (tuser = 1)
// emits the start object at position 0 and then, for each later position t,
// rescans every pair (placed object, unplaced object), reading one pair per
// cycle through the single read port of the matrix RAM. The input is not ready
// until the last position has been handed to the output register. object_count
// must not be written while an order is being built.

module vat_dissimilarity_reordering #(
    parameter int MAX_OBJECTS = vdr_pkg::MAX_OBJECTS_DEF,
    parameter int VALUE_BITS  = vdr_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [vdr_pkg::S_DATA_W-1:0]   i_s_tdata,  // row, col, dissimilarity, start_object
    input  logic [0:0]                     i_s_tuser,  // cmd
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [vdr_pkg::M_DATA_W-1:0]   o_m_tdata,  // position, object_index
    output logic                           o_m_tlast,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vdr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    import vdr_pkg::*;

    localparam int IW = (MAX_OBJECTS > 2) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam int AW = $clog2(MAX_OBJECTS * MAX_OBJECTS);

    t_state r_state, n_state;

    logic [COUNT_W-1:0]     r_object_count;
    logic [MAX_OBJECTS-1:0] r_chosen, n_chosen;
    logic [IW-1:0]          r_t, n_t;
    logic [IW-1:0]          r_k, n_k;
    logic [IW-1:0]          r_j, n_j;
    logic [IW-1:0]          r_a, n_a;
    logic                   r_p_valid, n_p_valid;
    logic [IW-1:0]          r_p_j, n_p_j;
    logic                   r_found, n_found;
    logic [VALUE_BITS-1:0]  r_best_val, n_best_val;
    logic [IW-1:0]          r_best, n_best;
    logic                   r_out_valid, n_out_valid;
    logic [IDX_W-1:0]       r_out_pos, n_out_pos;
    logic [IDX_W-1:0]       r_out_obj, n_out_obj;
    logic                   r_out_last, n_out_last;

    // ---------------- configuration ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_OBJECT_COUNT) ? {{(32-COUNT_W){1'b0}}, r_object_count}
                                                : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_object_count <= OBJ_COUNT_RESET;
        end else if (cfg_wr && paddr == REG_OBJECT_COUNT) begin
            r_object_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Objects in use, clamped to [2, MAX_OBJECTS]
    logic [CW-1:0] obj_n, obj_n_m1;
    always_comb begin
        if (r_object_count < 7'd2) begin
            obj_n = CW'(2);
        end else if (r_object_count > COUNT_W'(MAX_OBJECTS)) begin
            obj_n = CW'(MAX_OBJECTS);
        end else begin
            obj_n = CW'(r_object_count);
        end
        obj_n_m1 = obj_n - CW'(1);
    end

    // ---------------- input fields ----------------
    logic [IDX_W-1:0] in_row, in_col, in_start;
    logic [DIS_W-1:0] in_dis;
    logic             in_cmd;
    logic             load_ok;
    logic [IW-1:0]    ld_hi, ld_lo, start_c;

    assign in_row   = i_s_tdata[ROW_LSB +: IDX_W];
    assign in_col   = i_s_tdata[COL_LSB +: IDX_W];
    assign in_dis   = i_s_tdata[DIS_LSB +: DIS_W];
    assign in_start = i_s_tdata[START_LSB +: IDX_W];
    assign in_cmd   = i_s_tuser[0];

    assign load_ok = (COUNT_W'(in_row) < COUNT_W'(MAX_OBJECTS)) &&
                     (COUNT_W'(in_col) < COUNT_W'(MAX_OBJECTS));
    // Symmetric store: only the (larger, smaller) half is kept
    assign ld_hi   = (in_row > in_col) ? IW'(in_row) : IW'(in_col);
    assign ld_lo   = (in_row > in_col) ? IW'(in_col) : IW'(in_row);
    assign start_c = (COUNT_W'(in_start) >= COUNT_W'(obj_n)) ? IW'(obj_n_m1) : IW'(in_start);

    // ---------------- memories ----------------
    logic                  mat_we;
    logic [AW-1:0]         mat_waddr, mat_raddr;
    logic [VALUE_BITS-1:0] mat_rdata;
    logic [IW-1:0]         sc_hi, sc_lo;
    logic                  ord_we;
    logic [IW-1:0]         ord_rdata;

    assign sc_hi     = (r_a > r_j) ? r_a : r_j;
    assign sc_lo     = (r_a > r_j) ? r_j : r_a;
    assign mat_waddr = AW'(ld_hi * MAX_OBJECTS) + AW'(ld_lo);
    assign mat_raddr = AW'(sc_hi * MAX_OBJECTS) + AW'(sc_lo);

    vdr_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_OBJECTS * MAX_OBJECTS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (VALUE_BITS'(in_dis)),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    vdr_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_OBJECTS)
    ) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (r_t),
        .i_wdata (r_best),
        .i_raddr (r_k),
        .o_rdata (ord_rdata)
    );

    // ---------------- sequencer ----------------
    logic out_free;
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_chosen    = r_chosen;
        n_t         = r_t;
        n_k         = r_k;
        n_j         = r_j;
        n_a         = r_a;
        n_p_valid   = 1'b0;
        n_p_j       = r_p_j;
        n_found     = r_found;
        n_best_val  = r_best_val;
        n_best      = r_best;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_pos   = r_out_pos;
        n_out_obj   = r_out_obj;
        n_out_last  = r_out_last;
        mat_we      = 1'b0;
        ord_we      = 1'b0;

        // compare stage: strict less keeps the earliest pair on ties
        if (r_p_valid && (!r_found || mat_rdata < r_best_val)) begin
            n_found    = 1'b1;
            n_best_val = mat_rdata;
            n_best     = r_p_j;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (in_cmd == CMD_LOAD) begin
                        mat_we = load_ok;
                    end else begin
                        n_chosen = '0;
                        n_best   = start_c;
                        n_t      = '0;
                        n_state  = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out_pos          = IDX_W'(r_t);
                    n_out_obj          = IDX_W'(r_best);
                    n_out_last         = (CW'(r_t) == obj_n_m1);
                    n_chosen[r_best]   = 1'b1;
                    ord_we             = 1'b1;
                    if (CW'(r_t) == obj_n_m1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_t     = r_t + IW'(1);
                        n_k     = '0;
                        n_found = 1'b0;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // order RAM is read at r_k here
                if (r_k == r_t) begin
                    n_state = ST_COMMIT;
                end else begin
                    n_state = ST_GET_A;
                end
            end
            ST_GET_A: begin
                n_a     = ord_rdata;
                n_j     = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                n_p_valid = !r_chosen[r_j];
                n_p_j     = r_j;
                if (CW'(r_j) == obj_n_m1) begin
                    n_k     = r_k + IW'(1);
                    n_state = ST_CHECK;
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chosen    <= '0;
            r_p_valid   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chosen    <= n_chosen;
            r_p_valid   <= n_p_valid;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t        <= n_t;
        r_k        <= n_k;
        r_j        <= n_j;
        r_a        <= n_a;
        r_p_j      <= n_p_j;
        r_best_val <= n_best_val;
        r_best     <= n_best;
        r_out_pos  <= n_out_pos;
        r_out_obj  <= n_out_obj;
        r_out_last <= n_out_last;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W-2*IDX_W){1'b0}}, r_out_obj, r_out_pos};
    assign o_m_tlast  = r_out_last;

endmodule

/* hdl/vdr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the dissimilarity matrix and the order list; depends on nothing.
`timescale 1ns / 1ps

module vdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for vat_dissimilarity_reordering: loads, starts and
// ordering checks. Depends on vdr_pkg and the RTL of the block.
`timescale 1ns / 1ps

import vdr_pkg::*;

typedef struct packed {
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] object_index;
    logic             last;
} t_placement;

// Tracks the matrix and object count, predicts each order, checks placements
class reorder_scoreboard;
    logic [DIS_W-1:0]   dis_mem [MAX_OBJECTS_DEF*MAX_OBJECTS_DEF];
    logic [COUNT_W-1:0] count_reg;
    t_placement         expected_order [$];
    int                 errors;
    int                 orders_built;
    int                 placements_checked;

    function new();
        foreach (dis_mem[i]) dis_mem[i] = '0;
        count_reg          = OBJ_COUNT_RESET;
        errors             = 0;
        orders_built       = 0;
        placements_checked = 0;
    endfunction

    function void predict_order(logic [IDX_W-1:0] first);
        int n, s, t, k, j, best_obj;
        bit chosen [MAX_OBJECTS_DEF];
        int placed [MAX_OBJECTS_DEF];
        logic [DIS_W-1:0] best_val, d;
        bit found;
        t_placement p;
        n = count_reg;
        if (n < 2) n = 2;
        if (n > MAX_OBJECTS_DEF) n = MAX_OBJECTS_DEF;
        s = first;
        if (s >= n) s = n - 1;
        foreach (chosen[i]) chosen[i] = 1'b0;
        placed[0] = s;
        chosen[s] = 1'b1;
        p.position     = '0;
        p.object_index = s[IDX_W-1:0];
        p.last         = 1'b0;
        expected_order = {expected_order, p};
        for (t = 1; t < n; t++) begin
            found    = 1'b0;
            best_val = '0;
            best_obj = 0;
            // earliest placed object first, then lowest index; ties never replace
            for (k = 0; k < t; k++) begin
                for (j = 0; j < n; j++) begin
                    if (!chosen[j]) begin
                        d = dis_mem[placed[k]*MAX_OBJECTS_DEF + j];
                        if (!found || d < best_val) begin
                            found    = 1'b1;
                            best_val = d;
                            best_obj = j;
                        end
                    end
                end
            end
            placed[t]        = best_obj;
            chosen[best_obj] = 1'b1;
            p.position       = t[IDX_W-1:0];
            p.object_index   = best_obj[IDX_W-1:0];
            p.last           = (t == n - 1);
            expected_order   = {expected_order, p};
        end
        orders_built++;
    endfunction

    function void note_word(logic cmd, logic [S_DATA_W-1:0] data);
        int r, c;
        r = data[ROW_LSB +: IDX_W];
        c = data[COL_LSB +: IDX_W];
        if (cmd == CMD_LOAD) begin
            dis_mem[r*MAX_OBJECTS_DEF + c] = data[DIS_LSB +: DIS_W];
            dis_mem[c*MAX_OBJECTS_DEF + r] = data[DIS_LSB +: DIS_W];
        end else begin
            predict_order(data[START_LSB +: IDX_W]);
        end
    endfunction

    function void check_position(logic [M_DATA_W-1:0] data, logic last);
        t_placement want;
        t_placement got;
        got.position     = data[IDX_W-1:0];
        got.object_index = data[2*IDX_W-1:IDX_W];
        got.last         = last;
        if (expected_order.size() == 0) begin
            $display("%0t: unexpected word pos=%0d obj=%0d last=%0b",
                     $time, got.position, got.object_index, got.last);
            errors++;
            return;
        end
        want = expected_order.pop_front();
        placements_checked++;
        if (got.position != want.position) begin
            $display("%0t: position mismatch exp=%0d act=%0d",
                     $time, want.position, got.position);
            errors++;
        end
        if (got.object_index != want.object_index) begin
            $display("%0t: object mismatch at pos %0d exp=%0d act=%0d",
                     $time, want.position, want.object_index, got.object_index);
            errors++;
        end
        if (got.last != want.last) begin
            $display("%0t: last flag mismatch at pos %0d exp=%0b act=%0b",
                     $time, want.position, want.last, got.last);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int N_MAX       = MAX_OBJECTS_DEF;
    localparam int RAND_WORDS  = 280;
    localparam int STALL_LIMIT = 50000;
    localparam int DRAIN_WAIT  = 8;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata  = '0;  // row, col, dissimilarity, start_object
    logic [0:0]            i_s_tuser  = '0;  // cmd
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;        // position, object_index
    logic                  o_m_tlast;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [31:0]           pwdata     = '0;
    logic [31:0]           prdata;
    logic                  pready;

    reorder_scoreboard sb = new();

    bit loaded [N_MAX][N_MAX];
    int burst_left = 0;
    int words_sent = 0;
    int ready_mode = 0;
    int pat_left   = 0;

    vat_dissimilarity_reordering dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: runs of always-ready, coin-flip and mostly-stalled cycles
    always @(negedge i_clk) begin
        if (pat_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            pat_left   = $urandom_range(8, 64);
        end
        pat_left--;
        case (ready_mode)
            0, 1: begin
                i_m_tready <= 1'b1;
            end
            2: begin
                i_m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_position(o_m_tdata, o_m_tlast);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [S_DATA_W-1:0] pack_word(int row, int col, int dis, int first);
        logic [S_DATA_W-1:0] w;
        w = '0;
        w[ROW_LSB +: IDX_W]   = row[IDX_W-1:0];
        w[COL_LSB +: IDX_W]   = col[IDX_W-1:0];
        w[DIS_LSB +: DIS_W]   = dis[DIS_W-1:0];
        w[START_LSB +: IDX_W] = first[IDX_W-1:0];
        return w;
    endfunction

    function automatic int rand_dis(int mode);
        case (mode)
            0: return $urandom_range(0, 3);          // dense ties
            1: return $urandom_range(0, 16'hFFFF);
            default: return $urandom_range(16'hFFF0, 16'hFFFF);
        endcase
    endfunction

    // All tasks start and end at a falling edge
    task automatic send_word(input logic cmd, input logic [S_DATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            i_s_tvalid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = cmd;
        i_s_tdata  = data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_word(cmd, data);
        burst_left--;
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_pair(input int row, input int col, input int dis);
        send_word(CMD_LOAD, pack_word(row, col, dis, $urandom_range(0, 63)));
        loaded[row][col] = 1'b1;
        loaded[col][row] = 1'b1;
    endtask

    task automatic start_order(input int first);
        send_word(CMD_START, pack_word($urandom_range(0, 63), $urandom_range(0, 63),
                                       $urandom_range(0, 16'hFFFF), first));
    endtask

    // Every pair that a start over n objects reads must be loaded first
    task automatic fill_missing(input int n, input int mode);
        int r, c;
        for (r = 1; r < n; r++) begin
            for (c = 0; c < r; c++) begin
                if (!loaded[r][c]) begin
                    if ($urandom_range(0, 1)) load_pair(r, c, rand_dis(mode));
                    else load_pair(c, r, rand_dis(mode));
                end
            end
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (sb.expected_order.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = REG_OBJECT_COUNT;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic read_count_check();
        logic [31:0] rdata;
        apb_access(1'b0, 32'd0, rdata);
        if (rdata[COUNT_W-1:0] !== sb.count_reg) begin
            $display("%0t: object_count readback exp=%0d act=%0d",
                     $time, sb.count_reg, rdata[COUNT_W-1:0]);
            sb.errors++;
        end
    endtask

    task automatic set_count(input int value);
        logic [31:0] rdata;
        wait_drained();
        apb_access(1'b1, value, rdata);
        sb.count_reg = value[COUNT_W-1:0];
        if ($urandom_range(0, 1)) read_count_check();
    endtask

    initial begin : stimulus
        int base, pick, cnt, n, mode, r, c;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        read_count_check();

        // two objects, extreme values, start object saturating
        set_count(2);
        load_pair(1, 0, 16'hFFFF);
        start_order(0);
        start_order(63);
        // counts below two act as two
        set_count(0);
        start_order(1);

        // four objects with ties within and across placed objects
        set_count(4);
        load_pair(1, 0, 3);
        load_pair(0, 2, 3);                 // column above row still fills both
        load_pair(3, 0, 16'hFFFF);
        load_pair(2, 1, 3);
        load_pair(3, 1, 0);
        load_pair(3, 2, 3);
        load_pair(2, 2, 16'h1234);          // diagonal, never used in a comparison
        load_pair(63, 40, 0);               // outside the objects in use
        start_order(0);
        start_order(3);
        start_order(40);
        set_count(5);
        for (c = 0; c < 4; c++) load_pair(4, c, 3);
        start_order(2);

        // random orders, mostly small object counts
        base = words_sent;
        while (words_sent - base < RAND_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) cnt = $urandom_range(0, 1);
            else if (pick < 7) cnt = $urandom_range(2, 8);
            else cnt = $urandom_range(9, 16);
            set_count(cnt);
            n = (cnt < 2) ? 2 : cnt;
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(0, 6)) begin
                load_pair($urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_dis(mode));
            end
            repeat ($urandom_range(0, 2)) begin
                load_pair($urandom_range(0, 63), $urandom_range(0, 63), rand_dis(1));
            end
            fill_missing(n, mode);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 4) == 0) start_order($urandom_range(0, 63));
                else start_order($urandom_range(0, n - 1));
                repeat ($urandom_range(0, 2)) begin
                    r = $urandom_range(1, n - 1);
                    load_pair(r, $urandom_range(0, r - 1), rand_dis(mode));
                end
            end
        end

        // count above range is kept as written and read back unchanged
        set_count(127);
        read_count_check();

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d words; %0d orders predicted, %0d placements checked",
                 words_sent, sb.orders_built, sb.placements_checked);
        $display("Object counts 0 to 16 with saturating starts, dense ties, readback of 127");
        if (sb.errors == 0 && sb.expected_order.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
